/* design/lvbp_pkg.sv */
`default_nettype none
package lvbp_pkg;
  localparam int unsigned SCORE_W = 40;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_NEG_INF = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_BETA     = 2'd0,
    REG_GAMMA    = 2'd1,
    REG_OVERRIDE = 2'd2
  } reg_idx_e;

  typedef enum logic {
    KIND_EDGE   = 1'b0,
    KIND_FINISH = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_TRACE,
    ST_EMIT,
    ST_FAIL
  } back_state_e;

  // front to back queue word
  typedef struct packed {
    logic                      finish;
    logic                      relax;
    logic [6:0]                start;
    logic [6:0]                stop;
    logic signed [SCORE_W-1:0] best;
    logic [8:0]                node;
    logic [7:0]                unigram;
    logic [6:0]                total;
  } job_t;

  function automatic logic signed [SCORE_W-1:0] sat40(input logic signed [SCORE_W+1:0] x);
    logic signed [SCORE_W+1:0] mx;
    mx = {2'b00, SCORE_MAX};
    if (x > mx) begin
      return SCORE_MAX;
    end else if (x < -mx) begin
      return -SCORE_MAX;
    end
    return x[SCORE_W-1:0];
  endfunction
endpackage
`default_nettype wire

/* design/lvbp_front.sv */
`default_nettype none
module lvbp_front #(
  parameter int unsigned MAX_READINGS = 64,
  parameter int unsigned MAX_SPAN     = 8,
  parameter int unsigned MAX_NODES    = 512
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic signed [23:0]  beta_i,
  input  wire logic signed [31:0]  gamma_i,
  input  wire logic signed [31:0]  override_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                kind_i,
  input  wire logic [5:0]          node_start_i,
  input  wire logic [3:0]          span_length_i,
  input  wire logic [7:0]          unigram_index_i,
  input  wire logic signed [31:0]  lm_score_i,
  input  wire logic signed [31:0]  neural_score_i,
  input  wire logic                node_pinned_i,
  input  wire logic signed [8:0]   pin_index_i,
  input  wire logic                last_edge_i,
  input  wire logic [6:0]          total_length_i,
  output logic                     job_valid_o,
  input  wire logic                job_ready_i,
  output lvbp_pkg::job_t           job_o
);
  localparam int unsigned SW = lvbp_pkg::SCORE_W;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  // stage 1: product register
  logic                      s1_v_q;
  logic                      s1_kind_q, s1_pinned_q, s1_last_q;
  logic [5:0]                s1_start_q;
  logic [3:0]                s1_span_q;
  logic [7:0]                s1_uni_q;
  logic signed [31:0]        s1_lm_q;
  logic signed [55:0]        s1_prod_q;
  logic signed [8:0]         s1_pin_q;
  logic [6:0]                s1_total_q;

  logic signed [SW-1:0]      best_q, best_d;
  logic [7:0]                buni_q, buni_d;
  logic [CW-1:0]             cnt_q, cnt_d;

  logic                      out_v_q;
  lvbp_pkg::job_t            out_q, out_d;

  logic s1_go;
  assign s1_go      = s1_v_q && (!out_v_q || job_ready_i);
  assign in_ready_o = !s1_v_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_kind_q   <= kind_i;
      s1_pinned_q <= node_pinned_i;
      s1_last_q   <= last_edge_i;
      s1_start_q  <= node_start_i;
      s1_span_q   <= span_length_i;
      s1_uni_q    <= unigram_index_i;
      s1_lm_q     <= lm_score_i;
      s1_prod_q   <= 56'(beta_i * neural_score_i);
      s1_pin_q    <= pin_index_i;
      s1_total_q  <= total_length_i;
    end
  end

  logic signed [SW+1:0] w_raw;
  logic signed [SW-1:0] w, nb, ov;
  logic signed [55:0]   rnd;
  logic [7:0]           nu;
  logic [7:0]           end_pos;
  logic                 span_ok;

  always_comb begin
    rnd = (s1_prod_q + 56'sd32768) >>> 16;
    if (s1_pinned_q) begin
      w_raw = 42'(s1_lm_q);
    end else begin
      w_raw = 42'(s1_lm_q) + 42'(rnd) + 42'(gamma_i);
    end
    w = lvbp_pkg::sat40(w_raw);
    nb = best_q;
    nu = buni_q;
    if (w > best_q) begin
      nb = w;
      nu = s1_uni_q;
    end
    ov = lvbp_pkg::sat40(42'(override_i));
    if (!s1_pin_q[8]) begin
      nb = ov;
      nu = s1_pin_q[7:0];
    end
    end_pos = 8'(s1_start_q) + 8'(s1_span_q);
    span_ok = (s1_span_q != 4'd0) && (32'(s1_span_q) <= MAX_SPAN) &&
              (32'(end_pos) <= MAX_READINGS);

    best_d = best_q;
    buni_d = buni_q;
    cnt_d  = cnt_q;
    out_d  = out_q;
    if (s1_kind_q == lvbp_pkg::KIND_FINISH) begin
      best_d = lvbp_pkg::SCORE_NEG_INF;
      buni_d = '0;
      cnt_d  = '0;
      out_d  = '0;
      out_d.finish = 1'b1;
      out_d.total  = s1_total_q;
    end else if (s1_last_q) begin
      best_d = lvbp_pkg::SCORE_NEG_INF;
      buni_d = '0;
      out_d  = '0;
      if (32'(cnt_q) < MAX_NODES) begin
        cnt_d = cnt_q + CW'(1);
        out_d.relax   = span_ok && (nb != lvbp_pkg::SCORE_NEG_INF);
        out_d.start   = 7'(s1_start_q);
        out_d.stop    = end_pos[6:0];
        out_d.best    = nb;
        out_d.node    = 9'(cnt_q);
        out_d.unigram = nu;
      end
    end else begin
      best_d = (w > best_q) ? w : best_q;
      buni_d = (w > best_q) ? s1_uni_q : buni_q;
    end
  end

  logic emit;
  assign emit = s1_kind_q == lvbp_pkg::KIND_FINISH || (s1_last_q && 32'(cnt_q) < MAX_NODES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= lvbp_pkg::SCORE_NEG_INF;
      buni_q  <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (job_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (s1_go) begin
        best_q <= best_d;
        buni_q <= buni_d;
        cnt_q  <= cnt_d;
        if (emit) begin
          out_v_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && emit) begin
      out_q <= out_d;
    end
  end

  assign job_valid_o = out_v_q;
  assign job_o       = out_q;
endmodule
`default_nettype wire

/* design/lvbp_queue.sv */
`default_nettype none
module lvbp_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_valid_i,
  output logic            wr_ready_o,
  input  lvbp_pkg::job_t  wr_data_i,
  output logic            rd_valid_o,
  input  wire logic       rd_ready_i,
  output lvbp_pkg::job_t  rd_data_o
);
  lvbp_pkg::job_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

/* design/lvbp_ram.sv */
`default_nettype none
module lvbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* design/lvbp_back.sv */
`default_nettype none
module lvbp_back #(
  parameter int unsigned MAX_READINGS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  output logic             job_ready_o,
  input  lvbp_pkg::job_t   job_i,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output logic             path_ok_o,
  output logic [8:0]       node_index_o,
  output logic [7:0]       chosen_unigram_o,
  output logic             last_o
);
  localparam int unsigned NPOS = MAX_READINGS + 1;
  localparam int unsigned AW   = $clog2(NPOS);
  localparam int unsigned BW   = (MAX_READINGS > 1) ? $clog2(MAX_READINGS) : 1;
  localparam int unsigned SW   = lvbp_pkg::SCORE_W;
  localparam int unsigned EW   = SW + 1 + 7 + 9 + 8;

  // position entry: score, reached, from, node, unigram
  typedef struct packed {
    logic signed [SW-1:0] score;
    logic                 reached;
    logic [6:0]           from;
    logic [8:0]           node;
    logic [7:0]           uni;
  } pos_t;

  lvbp_pkg::back_state_e st_q, st_d;
  logic [1:0]   ph_q, ph_d;
  logic [AW-1:0] ra, wa, clr_q, clr_d;
  logic          we;
  pos_t          wd, rd;
  logic [EW-1:0] rd_raw;
  logic [7:0]    cur_q, cur_d;
  logic [BW:0]   cnt_q, cnt_d;
  logic          bwe;
  logic [BW-1:0] bwa, bra;
  logic [16:0]   bwd, brd;
  pos_t          s0_q, s0_d;
  logic          ov_q, ov_d;
  lvbp_pkg::job_t j;
  logic [16:0]   o_q, o_d;
  logic          ol_q, ol_d, ook_q, ook_d;

  assign j  = job_i;
  assign rd = pos_t'(rd_raw);

  lvbp_ram #(.WIDTH(EW), .DEPTH(NPOS)) u_pos (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(EW'(wd)), .raddr_i(ra), .rdata_o(rd_raw)
  );
  lvbp_ram #(.WIDTH(17), .DEPTH(MAX_READINGS)) u_path (
    .clk_i, .we_i(bwe), .waddr_i(bwa), .wdata_i(bwd), .raddr_i(bra), .rdata_o(brd)
  );

  logic signed [SW+1:0] sum;

  always_comb begin
    st_d = st_q; ph_d = ph_q; clr_d = clr_q; cur_d = cur_q; cnt_d = cnt_q;
    s0_d = s0_q; ov_d = ov_q; o_d = o_q; ol_d = ol_q; ook_d = ook_q;
    job_ready_o = 1'b0;
    we = 1'b0; wa = '0; wd = '0; ra = '0;
    bwe = 1'b0; bwa = '0; bwd = '0; bra = '0;
    sum = '0;
    case (st_q)
      lvbp_pkg::ST_CLEAR: begin
        we = 1'b1; wa = clr_q;
        wd = '0;
        wd.score = (clr_q == '0) ? '0 : lvbp_pkg::SCORE_NEG_INF;
        clr_d = clr_q + AW'(1);
        if (32'(clr_q) == NPOS - 1) st_d = lvbp_pkg::ST_IDLE;
      end
      lvbp_pkg::ST_IDLE: begin
        if (!ov_q && job_valid_i) begin
          if (j.finish) begin
            job_ready_o = 1'b1;
            if (j.total == 7'd0 || 32'(j.total) > MAX_READINGS) begin
              st_d = lvbp_pkg::ST_FAIL;
            end else begin
              cur_d = 8'(j.total); cnt_d = '0; ph_d = 2'd0;
              st_d = lvbp_pkg::ST_TRACE;
            end
          end else if (!j.relax) begin
            job_ready_o = 1'b1;
          end else begin
            // read-modify-write: read start, read stop, then write stop
            case (ph_q)
              2'd0: begin ra = AW'(j.start); ph_d = 2'd1; end
              2'd1: begin ra = AW'(j.stop); s0_d = rd; ph_d = 2'd2; end
              default: begin
                job_ready_o = 1'b1; ph_d = 2'd0;
                sum = 42'(s0_q.score) + 42'(j.best);
                wd.score = lvbp_pkg::sat40(sum);
                wd.reached = 1'b1; wd.from = j.start; wd.node = j.node;
                wd.uni = j.unigram;
                wa = AW'(j.stop);
                we = (s0_q.score != lvbp_pkg::SCORE_NEG_INF) && (wd.score > rd.score);
              end
            endcase
          end
        end
      end
      lvbp_pkg::ST_TRACE: begin
        ra = AW'(cur_q);
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          ph_d = 2'd0;
          if (!rd.reached) begin
            st_d = lvbp_pkg::ST_FAIL;
          end else begin
            bwe = 1'b1; bwa = cnt_q[BW-1:0]; bwd = {rd.node, rd.uni};
            cnt_d = cnt_q + (BW+1)'(1);
            cur_d = 8'(rd.from);
            if (rd.from == 7'd0 || 32'(cnt_d) >= MAX_READINGS) begin
              st_d = lvbp_pkg::ST_EMIT;
            end
          end
        end
      end
      lvbp_pkg::ST_EMIT: begin
        bra = BW'(cnt_q - (BW+1)'(1));
        if (!ov_q || m_ready_i) begin
          if (ph_q == 2'd0) begin
            ph_d = 2'd1;
            if (ov_q) ov_d = 1'b0;
          end else begin
            ov_d = 1'b1; ook_d = 1'b1; o_d = brd; ph_d = 2'd0;
            cnt_d = cnt_q - (BW+1)'(1);
            ol_d = cnt_q == (BW+1)'(1);
            if (ol_d) begin st_d = lvbp_pkg::ST_CLEAR; clr_d = '0; end
          end
        end
      end
      lvbp_pkg::ST_FAIL: begin
        if (!ov_q || m_ready_i) begin
          ov_d = 1'b1; ook_d = 1'b0; o_d = '0; ol_d = 1'b1;
          st_d = lvbp_pkg::ST_CLEAR; clr_d = '0;
        end
      end
      default: st_d = lvbp_pkg::ST_IDLE;
    endcase
    if (ov_q && m_ready_i && !(ov_d && st_q != lvbp_pkg::ST_IDLE && ov_d != ov_q)) begin
      if (!((st_q == lvbp_pkg::ST_EMIT && ph_q == 2'd1) || st_q == lvbp_pkg::ST_FAIL)) begin
        ov_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= lvbp_pkg::ST_CLEAR; ph_q <= '0; clr_q <= '0; ov_q <= 1'b0;
      cur_q <= '0; cnt_q <= '0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; clr_q <= clr_d; ov_q <= ov_d;
      cur_q <= cur_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d; o_q <= o_d; ol_q <= ol_d; ook_q <= ook_d;
  end

  assign m_valid_o        = ov_q;
  assign path_ok_o        = ook_q;
  assign node_index_o     = o_q[16:8];
  assign chosen_unigram_o = o_q[7:0];
  assign last_o           = ol_q;
endmodule
`default_nettype wire

/* design/lattice_viterbi_best_path.sv */
// lattice best-path search
// s_axis carries edge and finish words; edges of one node arrive together,
// the last edge commits the node and relaxes its end position.
// a finish word backtraces from total_length and returns the picks on
// m_axis in forward order, tlast on the final one, or one failure word.
// cfg channel writes beta, gamma and override; the user must write them
// only while idle (not enforced). front: one edge per cycle unless the
// queue is full (multiply, then weigh/compare); commits go via a
// two-entry queue to the back end. back: each commit reads start and end,
// then writes, on the position memory port; edges that commit nothing cost
// nothing there. backtrace follows one position at a time, emit reads each
// word, then sends it. after reset and every finish all MAX_READINGS+1
// position entries are cleared, one a cycle; finish words wait for it. a
// stalled m_axis holds its word and backs up the queue and the front.
`default_nettype none
module lattice_viterbi_best_path #(
  parameter int unsigned MAX_READINGS = 64,
  parameter int unsigned MAX_SPAN     = 8,
  parameter int unsigned MAX_NODES    = 512
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // node_start, span_length, unigram_index, lm_score, neural_score,
  // node_pinned, pin_index, last_edge, total_length
  input  wire logic [103:0] s_axis_tdata,
  // kind
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // node_index, chosen_unigram
  output logic [23:0]       m_axis_tdata,
  // path_ok
  output logic              m_axis_tuser,
  output logic              m_axis_tlast
);
  logic signed [23:0] beta_q;
  logic signed [31:0] gamma_q, over_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= '0; gamma_q <= '0; over_q <= 32'sd2752512;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lvbp_pkg::REG_BETA:     beta_q  <= cfg_data_i[23:0];
        lvbp_pkg::REG_GAMMA:    gamma_q <= cfg_data_i;
        lvbp_pkg::REG_OVERRIDE: over_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic fj_v, fj_r, qj_v, qj_r;
  lvbp_pkg::job_t fj, qj;

  lvbp_front #(.MAX_READINGS(MAX_READINGS), .MAX_SPAN(MAX_SPAN), .MAX_NODES(MAX_NODES)) u_front (
    .clk_i, .rst_ni, .beta_i(beta_q), .gamma_i(gamma_q), .override_i(over_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .kind_i(s_axis_tuser), .node_start_i(s_axis_tdata[5:0]),
    .span_length_i(s_axis_tdata[9:6]), .unigram_index_i(s_axis_tdata[17:10]),
    .lm_score_i(s_axis_tdata[49:18]), .neural_score_i(s_axis_tdata[81:50]),
    .node_pinned_i(s_axis_tdata[82]), .pin_index_i(s_axis_tdata[91:83]),
    .last_edge_i(s_axis_tdata[92]), .total_length_i(s_axis_tdata[99:93]),
    .job_valid_o(fj_v), .job_ready_i(fj_r), .job_o(fj)
  );

  lvbp_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fj_v), .wr_ready_o(fj_r), .wr_data_i(fj),
    .rd_valid_o(qj_v), .rd_ready_i(qj_r), .rd_data_o(qj)
  );

  logic [8:0] ni;
  logic [7:0] cu;

  lvbp_back #(.MAX_READINGS(MAX_READINGS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(qj_v), .job_ready_o(qj_r), .job_i(qj),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .path_ok_o(m_axis_tuser), .node_index_o(ni), .chosen_unigram_o(cu),
    .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, cu, ni};

  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast) else $error("fail word not last");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata[16:0] == 17'd0)
    else $error("fail word not zero");
endmodule
`default_nettype wire
